// File: rtl/sspc_pkg.sv
package sspc_pkg;

  // Default sizing of the side stack and of one sequence value.
  localparam int DEF_STACK_DEPTH = 1024;
  localparam int DEF_VALUE_BITS  = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the arriving value: emit, push or flag overflow
    logic pop;     // drop the stack top, advance the counter, read the new top
    logic fetch;   // load the stack top register from the memory read data
    logic emit;    // register the result and return to the start state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic top_match;  // stack is not empty and its top equals the counter
    logic last;       // the item in work is the final one of its sequence
  } status_t;

endpackage

// File: rtl/sspc_ctrl.sv
module sspc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  sspc_pkg::status_t st,
  output sspc_pkg::cmd_t    cmd
);
  import sspc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Sequencer: take an item, pop the stack while its top matches, and emit the result after a final item.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (st.top_match) begin
          cmd.pop    = 1'b1;
          state_next = ST_FETCH;
        end else if (st.last) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_DRAIN;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The result stays valid until the receiver takes the transfer.
  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Every accepted item gets a drain check in the next cycle.
  a_accept_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == ST_DRAIN)
    else $error("accepted item not followed by a drain check");

  // A pop is always followed by loading the new stack top.
  a_pop_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> cmd.fetch)
    else $error("pop not followed by a top fetch");

  // An emitted result is presented in the following cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

endmodule

// File: rtl/sspc_datapath.sv
module sspc_datapath #(
  parameter int STACK_DEPTH = sspc_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_BITS  = sspc_pkg::DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  last,
  input  sspc_pkg::cmd_t        cmd,
  output sspc_pkg::status_t     st,
  output logic                  sortable,
  output logic                  overflow
);
  import sspc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int NW = VALUE_BITS + 1;

  logic [VALUE_BITS-1:0] stack_mem [STACK_DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic [VALUE_BITS-1:0] top;
  logic [CW-1:0]         count;
  logic [NW-1:0]         next_exp;
  logic                  ovf;
  logic                  last_r;
  logic                  hit;
  logic                  full;
  logic                  push;
  logic [CW-1:0]         below_top;

  assign hit       = (NW'(value) == next_exp);
  assign full      = (count == CW'(STACK_DEPTH));
  assign push      = cmd.accept && !hit && !full;
  assign below_top = count - CW'(2);

  assign st.top_match = (count != '0) && (NW'(top) == next_exp);
  assign st.last      = last_r;

  // Side stack memory: push writes at the fill count, a pop reads the entry
  // that becomes the new top.
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[count[AW-1:0]] <= value;
    end
    if (cmd.pop) begin
      rd_data <= stack_mem[below_top[AW-1:0]];
    end
  end

  // Stack top register, refreshed on push and after a pop's read.
  always_ff @(posedge clk) begin
    if (push) begin
      top <= value;
    end else if (cmd.fetch) begin
      top <= rd_data;
    end
    if (cmd.accept) begin
      last_r <= last;
    end
  end

  // Counter, fill count and sticky overflow flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      count    <= '0;
      next_exp <= NW'(1);
      ovf      <= 1'b0;
    end else if (cmd.accept) begin
      if (hit) begin
        next_exp <= next_exp + NW'(1);
      end else if (!full) begin
        count <= count + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end else if (cmd.pop) begin
      count    <= count - CW'(1);
      next_exp <= next_exp + NW'(1);
    end
  end

  // Result register, loaded from the sequence state on the edge that clears it.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sortable <= !ovf && (count == '0);
      overflow <= ovf;
    end
  end

  // A pop only happens on a non-empty stack.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("pop on an empty stack");

  // After a result the sequence state is back at its start.
  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (count == '0) && (next_exp == NW'(1)) && !ovf)
    else $error("sequence state not cleared after result");

  // The fill count never passes the stack depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack fill count beyond the stack depth");

endmodule

// File: rtl/stack_sortable_permutation_check_core.sv
// Single-stack sortability check.
// The input channel (in_valid, in_stall, value, last) carries one element of
// a sequence per transfer; last marks the final element. The output channel
// (out_valid, out_stall, sortable, overflow) carries one result per
// sequence: sortable is 1 when the sequence can be emitted as 1,2,3,...
// through the side stack with no overflow, and overflow reports that a push
// was refused because the stack was full.
// Sequence: each element passes a transfer and a drain check, and every
// entry popped off the stack adds a pop and a fetch of the new top through
// the registered memory read. A final element then passes the emit state,
// which loads the result register and sets out_valid. in_stall is high
// while an element is in work. If the receiver stalls, the result is held,
// and a following final element keeps in_stall high until the output
// register frees, so no new element is taken meanwhile. Reset clears the
// counters, the sticky flag, the state and out_valid; the stack memory and
// the result register need no clearing.
module stack_sortable_permutation_check_core #(
  parameter int STACK_DEPTH = sspc_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_BITS  = sspc_pkg::DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  sortable,
  output logic                  overflow
);
  import sspc_pkg::*;

  cmd_t    cmd;
  status_t st;

  sspc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  sspc_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .value    (value),
    .last     (last),
    .cmd      (cmd),
    .st       (st),
    .sortable (sortable),
    .overflow (overflow)
  );

endmodule

// File: tb/stack_sortable_permutation_check_core_tb.sv
module stack_sortable_permutation_check_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW    = sspc_pkg::DEF_VALUE_BITS;
  localparam int DEPTH = sspc_pkg::DEF_STACK_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int RANDOM_ELEMENTS = 600;

  // One sequence element as it waits to be driven.
  typedef struct packed {
    logic [VW-1:0] val;
    logic          tail;
  } element_t;

  // One per-sequence answer.
  typedef struct packed {
    logic sortable;
    logic overflow;
  } verdict_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [VW-1:0] value = '0;
  logic          last = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          sortable;
  logic          overflow;

  element_t pending_q[$];
  verdict_t verdict_q[$];
  int       build_q[$];
  int       mismatches = 0;
  int       cycle_cnt = 0;
  logic     calm;

  // Shadow copy of the block's state.
  logic [VW-1:0] shadow_stack [DEPTH];
  int            shadow_count = 0;
  logic [VW:0]   shadow_next = (VW+1)'(1);
  logic          shadow_overflowed = 1'b0;

  stack_sortable_permutation_check_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sortable  (sortable),
    .overflow  (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // In the calm window of each cycle_cnt period, neither side idles or stalls.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end
  assign calm = (cycle_cnt % 3000) >= 2200;

  // Apply one element to the shadow state; returns 1 when it closes a sequence.
  function automatic bit judge_element(input logic [VW-1:0] v, input logic fin,
                                       output verdict_t res);
    int top_idx;
    res = '0;
    if ({1'b0, v} == shadow_next) begin
      shadow_next++;
    end else if (shadow_count < DEPTH) begin
      shadow_stack[shadow_count[AW-1:0]] = v;
      shadow_count++;
    end else begin
      shadow_overflowed = 1'b1;
    end
    // Pop the stack top while it is the next number due.
    while (shadow_count > 0) begin
      top_idx = shadow_count - 1;
      if ({1'b0, shadow_stack[top_idx[AW-1:0]]} != shadow_next) break;
      shadow_count--;
      shadow_next++;
    end
    if (!fin) return 1'b0;
    res.sortable = !shadow_overflowed && shadow_count == 0;
    res.overflow = shadow_overflowed;
    shadow_count = 0;
    shadow_next = (VW+1)'(1);
    shadow_overflowed = 1'b0;
    return 1'b1;
  endfunction

  // Input driver: predicts on each transfer and then offers the next element.
  always @(posedge clk) begin
    verdict_t res;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (judge_element(value, last, res)) verdict_q.insert(verdict_q.size(), res);
      end
      if (!(in_valid && in_stall)) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
          value    <= pending_q[0].val;
          last     <= pending_q[0].tail;
          in_valid <= 1'b1;
          pending_q.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each result transfer and drives random stalls.
  always @(posedge clk) begin
    verdict_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected result sortable=%0b overflow=%0b",
                     sortable, overflow);
        end else begin
          exp_res = verdict_q[0];
          verdict_q.delete(0);
          if (sortable !== exp_res.sortable || overflow !== exp_res.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected sortable=%0b overflow=%0b, ",
                        "got sortable=%0b overflow=%0b"},
                       exp_res.sortable, exp_res.overflow, sortable, overflow);
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 20);
    end
  end

  // Queue the values collected in build_q as one sequence.
  task automatic send_build();
    element_t e;
    for (int i = 0; i < build_q.size(); i++) begin
      e.val  = build_q[i][VW-1:0];
      e.tail = (i == build_q.size() - 1);
      pending_q.insert(pending_q.size(), e);
    end
  endtask

  // Build a sequence that one stack can sort, from a random push/pop walk.
  task automatic make_sortable(input int n);
    int holes[$];
    int pushes;
    int due;
    int slot;
    build_q.delete();
    pushes = 0;
    due = 1;
    while (pushes < n || holes.size() > 0) begin
      if (pushes < n && (holes.size() == 0 || $urandom_range(1) == 1)) begin
        build_q.insert(build_q.size(), 0);
        holes.insert(holes.size(), build_q.size() - 1);
        pushes++;
      end else begin
        slot = holes[$];
        holes.delete(holes.size() - 1);
        build_q[slot] = due;
        due++;
      end
    end
  endtask

  // Random permutation of 1..n.
  task automatic make_shuffle(input int n);
    int j;
    int t;
    build_q.delete();
    for (int i = 1; i <= n; i++) build_q.insert(build_q.size(), i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = build_q[i];
      build_q[i] = build_q[j];
      build_q[j] = t;
    end
  endtask

  // Stimulus: directed cases, the stack-depth cases, then random sequences.
  initial begin
    int sent;
    int n;
    int kind;
    int pos;

    // Single-element and short sequences, zero and the value extremes.
    build_q = '{1};            send_build();
    build_q = '{0};            send_build();
    build_q = '{65535};        send_build();
    build_q = '{2, 1};         send_build();
    build_q = '{2, 3, 1};      send_build();
    build_q = '{3, 1, 2};      send_build();
    build_q = '{1, 0, 2};      send_build();
    build_q = '{1, 1};         send_build();
    build_q = '{32768, 1};     send_build();
    build_q = '{21845, 43690}; send_build();

    // Exactly fill the stack, then drain all of it.
    build_q.delete();
    for (int v = DEPTH + 1; v >= 1; v--) build_q.insert(build_q.size(), v);
    send_build();
    // One push more than the stack holds.
    build_q.delete();
    for (int v = DEPTH + 2; v >= 1; v--) build_q.insert(build_q.size(), v);
    send_build();
    // State must be clean again after the overflow.
    build_q = '{1};            send_build();

    // Random sequences: mostly sortable, plus shuffles, noise and damaged ones.
    sent = 0;
    while (sent < RANDOM_ELEMENTS) begin
      n = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 60);
      kind = $urandom_range(99);
      if (kind < 60) begin
        make_sortable(n);
      end else if (kind < 75) begin
        make_shuffle(n);
      end else if (kind < 90) begin
        build_q.delete();
        for (int i = 0; i < n; i++)
          build_q.insert(build_q.size(),
                         $urandom_range(1) ? $urandom_range(65535) : $urandom_range(n + 2));
      end else begin
        make_sortable(n);
        pos = $urandom_range(n - 1);
        if ($urandom_range(1)) build_q[pos] = $urandom_range(n + 1);
        else build_q.insert(pos, build_q[pos]);
      end
      send_build();
      sent += build_q.size();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last transfer and the last result, then a quiet tail.
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
